>>> sv/ogrr_pkg.sv
// Shared types, constants and the sine table for the occupancy grid ray range block.
// No dependencies; every module of the block imports it.
package ogrr_pkg;

    localparam int MAP_CELLS        = 65536;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int MAP_AW           = $clog2(MAP_CELLS);
    localparam int SIN_AW           = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int LIM_W            = 21;
    localparam int Q_DEPTH          = 2;
    localparam int Q_AW             = 1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [31:0] HIT_BACKOFF   = 32'sd1311;
    localparam logic signed [31:0] LIMIT_BACKOFF = 32'sd6554;
    localparam logic signed [31:0] OFF_DEPTH     = -32'sd65536;

    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_LIMIT  = 2'd1;
    localparam logic [1:0] ST_OFFMAP = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RAY   = 1'b1;

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE   = 3'd2;
    localparam logic [2:0] REG_CELLS_PER_M = 3'd3;
    localparam logic [2:0] REG_MAP_WIDTH   = 3'd4;
    localparam logic [2:0] REG_MAP_CELLS   = 3'd5;
    localparam logic [2:0] REG_RANGE_LIMIT = 3'd6;

    typedef struct packed {
        logic               func;
        logic        [15:0] cell_index;
        logic signed [7:0]  cell_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
    } ogrr_in_t;

    typedef struct packed {
        logic signed [31:0] depth;
        logic        [1:0]  status;
    } ogrr_out_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic        [30:0] cell_size;
        logic        [30:0] cells_per_meter;
        logic        [15:0] map_width;
        logic        [16:0] map_cells;
        logic        [30:0] range_limit;
    } ogrr_cfg_t;

    // classified item handed from the front to the back
    typedef struct packed {
        logic               is_ray;
        logic        [15:0] cell_index;
        logic               occupied;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [17:0] sin_q16;
        logic signed [17:0] cos_q16;
    } ogrr_cmd_t;

    typedef struct packed {
        logic clearing;
    } ogrr_back_status_t;

    typedef struct packed {
        logic        ok;
        logic [33:0] coord;
    } ogrr_coord_t;

    typedef logic [16:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    function automatic logic [16:0] sine_q16(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 8192) / 16384;
        if (sum > 65536) begin
            sum = 65536;
        end
        return 17'(sum);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            rom[k] = sine_q16((64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // offset along one axis: length times trig, magnitude truncated
    function automatic logic signed [32:0] scale_trig(input logic [31:0] len,
                                                       input logic signed [17:0] t);
        logic [16:0] mag;
        logic [48:0] prod;
        logic [32:0] off;
        mag  = t[17] ? 17'(-t) : 17'(t);
        prod = 49'(len) * 49'(mag);
        off  = {1'b0, prod[47:16]};
        return t[17] ? -$signed(off) : $signed(off);
    endfunction

    // cell coordinate, toward zero; negative point is off-map unless it truncates to 0
    // the product wraps at 64 bits before the shift
    function automatic ogrr_coord_t cell_coord(input logic signed [34:0] d,
                                               input logic [30:0] cpm);
        logic [34:0] mag;
        logic [63:0] prod;
        ogrr_coord_t r;
        mag  = d[34] ? 35'(-d) : 35'(d);
        prod = 64'(mag) * 64'(cpm);
        r.coord = d[34] ? 34'd0 : {2'b00, prod[63:32]};
        r.ok    = !d[34] || (prod[63:32] == 32'd0);
        return r;
    endfunction

endpackage

>>> sv/occupancy_grid_ray_range_top.sv
// Top level of the occupancy grid ray range block: configuration registers,
// front end, command queue and back end. Depends on ogrr_pkg and all ogrr_ modules.
//
// Input items arrive on s_valid/s_ready/s_data. A write item (func 0) sets or
// clears one map cell and gives no result. A ray item (func 1) gives one result
// item on m_valid/m_ready/m_data: the depth in Q16.16 and a status of hit,
// range limit or off-map. Registers are written via cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle; it is not enforced.
// After reset the back end sweeps the whole map to free, one cell a cycle;
// s_ready stays low during the sweep.
// The front end reads the sine table twice for a ray (states RD0 and RD1)
// and sends a write item straight to its push state. Per marched cell the
// back end steps through range check, offset multiply, coordinate multiply,
// index multiply, map read and hit check; this loop sets the cost of a ray,
// which grows with range_limit / cell_size. A write item is applied on pop.
// The result stays in an output register while m_ready is low; the back end
// then holds, and the two-entry queue lets the front end take further items.
module occupancy_grid_ray_range_top
    import ogrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ogrr_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ogrr_out_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    ogrr_cfg_t          cfg_reg;
    ogrr_back_status_t  back_status;
    logic               push, q_full, q_pop, q_valid;
    ogrr_cmd_t          push_cmd, head_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.cell_size       <= 31'd3277;
            cfg_reg.cells_per_meter <= 31'd1310720;
            cfg_reg.map_width       <= 16'd256;
            cfg_reg.map_cells       <= 17'd65536;
            cfg_reg.range_limit     <= 31'd655360;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X:    cfg_reg.origin_x        <= $signed(cfg_wdata);
                REG_ORIGIN_Y:    cfg_reg.origin_y        <= $signed(cfg_wdata);
                REG_CELL_SIZE:   cfg_reg.cell_size       <= cfg_wdata[30:0];
                REG_CELLS_PER_M: cfg_reg.cells_per_meter <= cfg_wdata[30:0];
                REG_MAP_WIDTH:   cfg_reg.map_width       <= cfg_wdata[15:0];
                REG_MAP_CELLS:   cfg_reg.map_cells       <= cfg_wdata[16:0];
                REG_RANGE_LIMIT: cfg_reg.range_limit     <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    ogrr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .clearing (back_status.clearing),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    ogrr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    ogrr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .status  (back_status)
    );

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.clearing |-> !s_ready)
        else $error("item accepted during map clearing");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_HIT || m_data.status == ST_LIMIT
                     || m_data.status == ST_OFFMAP))
        else $error("result status out of range");

    a_offmap_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_OFFMAP) |-> (m_data.depth == OFF_DEPTH))
        else $error("off-map result with wrong depth");

    a_hit_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_HIT) |-> !m_data.depth[31])
        else $error("hit result with negative depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

>>> sv/ogrr_queue.sv
// Two-entry queue between the classifying front and the executing back.
// Depends on ogrr_pkg for the command type and depth.
module ogrr_queue
    import ogrr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  ogrr_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output ogrr_cmd_t head_cmd
);

    ogrr_cmd_t           entry_reg [0:Q_DEPTH-1];
    logic [Q_AW-1:0]     wptr_reg, wptr_next;
    logic [Q_AW-1:0]     rptr_reg, rptr_next;
    logic [Q_AW:0]       count_reg, count_next;

    assign full      = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push && !full) begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (pop && not_empty) begin
            rptr_next = rptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && not_empty)) begin
            count_next = count_reg + 1'b1;
        end else if (!(push && !full) && (pop && not_empty)) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/ogrr_front.sv
// Front end: takes input items, looks up sine and cosine for rays, queues commands.
// Depends on ogrr_pkg for types and the sine table.
module ogrr_front
    import ogrr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ogrr_in_t  s_data,
    input  logic      clearing,
    output logic      push,
    output ogrr_cmd_t push_cmd,
    input  logic      q_full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_RD0  = 4'b0010,
        F_RD1  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    front_state_t        state_reg, state_next;
    ogrr_in_t            item_reg;
    logic [SIN_AW-1:0]   idx_reg;
    logic [SIN_AW-1:0]   rom_addr;
    logic [16:0]         rom_q_reg;
    logic [16:0]         s0_reg;
    logic [31:0]         idx_prod;
    logic signed [17:0]  s0, c0;

    assign s_ready = (state_reg == F_IDLE) && !clearing;

    always_comb begin
        idx_prod = (32'(s_data.heading[13:0]) * 32'(SINE_TABLE_DEPTH)) >> 14;
        if (idx_prod > 32'(SINE_TABLE_DEPTH)) begin
            idx_prod = 32'(SINE_TABLE_DEPTH);
        end
    end

    assign rom_addr = (state_reg == F_RD0) ? idx_reg
                                           : SIN_AW'(SINE_TABLE_DEPTH) - idx_reg;

    always_ff @(posedge aclk) begin
        rom_q_reg <= SINE_ROM[rom_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = (s_data.func == FUNC_RAY) ? F_RD0 : F_PUSH;
                end
            end
            F_RD0: state_next = F_RD1;
            F_RD1: state_next = F_PUSH;
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
            idx_reg  <= SIN_AW'(idx_prod);
        end
        if (state_reg == F_RD1) begin
            s0_reg <= rom_q_reg;
        end
    end

    // rotate the first-quadrant pair into the heading's quadrant
    assign s0 = $signed({1'b0, s0_reg});
    assign c0 = $signed({1'b0, rom_q_reg});

    always_comb begin
        push_cmd            = '0;
        push_cmd.is_ray     = (item_reg.func == FUNC_RAY);
        push_cmd.cell_index = item_reg.cell_index;
        push_cmd.occupied   = (item_reg.cell_value > 8'sd0);
        push_cmd.pos_x      = item_reg.pos_x;
        push_cmd.pos_y      = item_reg.pos_y;
        case (item_reg.heading[15:14])
            QUAD_0: begin
                push_cmd.sin_q16 = s0;
                push_cmd.cos_q16 = c0;
            end
            QUAD_1: begin
                push_cmd.sin_q16 = c0;
                push_cmd.cos_q16 = -s0;
            end
            QUAD_2: begin
                push_cmd.sin_q16 = -s0;
                push_cmd.cos_q16 = -c0;
            end
            default: begin
                push_cmd.sin_q16 = -c0;
                push_cmd.cos_q16 = s0;
            end
        endcase
    end

    assign push = (state_reg == F_PUSH) && !q_full;

endmodule

>>> sv/ogrr_back.sv
// Back end: owns the occupancy map, applies map writes and marches rays.
// Depends on ogrr_pkg for types, constants and the coordinate functions.
module ogrr_back
    import ogrr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ogrr_cfg_t         cfg,
    input  logic              q_valid,
    input  ogrr_cmd_t         q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output ogrr_out_t         m_data,
    output ogrr_back_status_t status
);

    typedef enum logic [8:0] {
        B_CLEAR = 9'b000000001,
        B_IDLE  = 9'b000000010,
        B_STEP  = 9'b000000100,
        B_OFF   = 9'b000001000,
        B_COORD = 9'b000010000,
        B_IDX   = 9'b000100000,
        B_READ  = 9'b001000000,
        B_CHECK = 9'b010000000,
        B_DONE  = 9'b100000000
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [MAP_AW-1:0]   clr_addr_reg;
    ogrr_cmd_t           cmd_reg;
    logic [31:0]         len_reg;
    logic signed [32:0]  offx_reg, offy_reg;
    logic [33:0]         mx_reg, my_reg;
    logic                ok_reg;
    logic [50:0]         ci_reg;
    logic signed [31:0]  res_depth_reg, res_depth_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                m_valid_reg;
    ogrr_out_t           m_data_reg;

    logic                map_mem [0:MAP_CELLS-1];
    logic                rd_bit_reg;
    logic                mem_we;
    logic [MAP_AW-1:0]   mem_waddr;
    logic                mem_wdata;

    logic signed [34:0]  dx, dy;
    ogrr_coord_t         cx, cy;
    logic [LIM_W-1:0]    limit;
    logic                out_free;

    assign q_pop           = (state_reg == B_IDLE) && q_valid;
    assign status.clearing = (state_reg == B_CLEAR);
    assign out_free        = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

    assign dx = 35'(cmd_reg.pos_x) + 35'(offx_reg) - 35'(cfg.origin_x);
    assign dy = 35'(cmd_reg.pos_y) + 35'(offy_reg) - 35'(cfg.origin_y);
    assign cx = cell_coord(dx, cfg.cells_per_meter);
    assign cy = cell_coord(dy, cfg.cells_per_meter);

    assign limit = ({4'd0, cfg.map_cells} < LIM_W'(MAP_CELLS)) ? {4'd0, cfg.map_cells}
                                                              : LIM_W'(MAP_CELLS);

    // one write port: clearing sweep or a map write item
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = 1'b0;
        if (state_reg == B_CLEAR) begin
            mem_we = 1'b1;
        end else if (q_pop && !q_cmd.is_ray
                     && (LIM_W'(q_cmd.cell_index) < LIM_W'(MAP_CELLS))) begin
            mem_we    = 1'b1;
            mem_waddr = MAP_AW'(q_cmd.cell_index);
            mem_wdata = q_cmd.occupied;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_bit_reg <= map_mem[ci_reg[MAP_AW-1:0]];
    end

    always_comb begin
        state_next      = state_reg;
        res_depth_next  = res_depth_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            B_CLEAR: begin
                if (clr_addr_reg == MAP_AW'(MAP_CELLS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_valid && q_cmd.is_ray) begin
                    state_next = B_STEP;
                end
            end
            B_STEP: begin
                if (len_reg >= 32'(cfg.range_limit)) begin
                    res_depth_next  = $signed(32'(cfg.range_limit)) - LIMIT_BACKOFF;
                    res_status_next = ST_LIMIT;
                    state_next      = B_DONE;
                end else if (cfg.cell_size == '0) begin
                    res_depth_next  = OFF_DEPTH;
                    res_status_next = ST_OFFMAP;
                    state_next      = B_DONE;
                end else begin
                    state_next = B_OFF;
                end
            end
            B_OFF:   state_next = B_COORD;
            B_COORD: state_next = B_IDX;
            B_IDX:   state_next = B_READ;
            B_READ: begin
                if (!ok_reg || (ci_reg >= 51'(limit))) begin
                    res_depth_next  = OFF_DEPTH;
                    res_status_next = ST_OFFMAP;
                    state_next      = B_DONE;
                end else begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK: begin
                if (rd_bit_reg) begin
                    res_depth_next  = (len_reg > 32'(HIT_BACKOFF))
                                      ? $signed(len_reg) - HIT_BACKOFF : $signed(len_reg);
                    res_status_next = ST_HIT;
                    state_next      = B_DONE;
                end else begin
                    state_next = B_STEP;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if ((state_reg == B_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_depth_reg  <= res_depth_next;
        res_status_reg <= res_status_next;
        if (q_pop && q_cmd.is_ray) begin
            cmd_reg <= q_cmd;
            len_reg <= '0;
        end
        if (state_reg == B_OFF) begin
            offx_reg <= scale_trig(len_reg, cmd_reg.cos_q16);
            offy_reg <= scale_trig(len_reg, cmd_reg.sin_q16);
        end
        if (state_reg == B_COORD) begin
            mx_reg <= cx.coord;
            my_reg <= cy.coord;
            ok_reg <= cx.ok && cy.ok;
        end
        if (state_reg == B_IDX) begin
            ci_reg <= 51'(my_reg) * 51'(cfg.map_width) + 51'(mx_reg);
        end
        if ((state_reg == B_CHECK) && !rd_bit_reg) begin
            // advance one cell along the ray
            len_reg <= len_reg + 32'(cfg.cell_size);
        end
        if ((state_reg == B_DONE) && out_free) begin
            m_data_reg.depth  <= res_depth_reg;
            m_data_reg.status <= res_status_reg;
        end
    end

endmodule
